// ===== src/nrf_pkg.sv =====
// ---------------------------------------------------------------------------
// nrf_pkg
// shared constants and types of the near run finder
// ---------------------------------------------------------------------------
package nrf_pkg;

    localparam int MAX_SCAN_DEF  = 2048;
    localparam int BEAM_BITS_DEF = 12;

    localparam int RANGE_W       = 16;
    localparam int THRESH_W      = 16;
    localparam int ANGLE_START_W = 19;
    localparam int ANGLE_STEP_W  = 16;
    localparam int MIN_RUN_W     = 12;
    localparam int ANGLE_W       = 32;
    // wide enough for start + step * beam at the largest beam width, plus sign
    localparam int SUM_W         = 34;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    localparam logic [THRESH_W-1:0]             THRESH_RST      = 16'd2000;
    localparam logic signed [ANGLE_START_W-1:0] ANGLE_START_RST = -19'sd205887;
    localparam logic [ANGLE_STEP_W-1:0]         ANGLE_STEP_RST  = 16'd412;
    localparam logic [MIN_RUN_W-1:0]            MIN_RUN_RST     = 12'd22;

    typedef enum logic [1:0] {
        REG_NEAR_THRESHOLD,
        REG_ANGLE_START,
        REG_ANGLE_STEP,
        REG_MIN_RUN_POINTS
    } cfg_reg_t;

    typedef struct packed {
        logic [THRESH_W-1:0]             near_threshold_mm;
        logic signed [ANGLE_START_W-1:0] angle_start;
        logic [ANGLE_STEP_W-1:0]         angle_step;
        logic [MIN_RUN_W-1:0]            min_run_points;
    } cfg_t;

endpackage

// ===== src/nrf_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// nrf_cfg_regs
// apb register file: threshold, angle start, angle step, minimum run length
// ---------------------------------------------------------------------------
module nrf_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [nrf_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [nrf_pkg::APB_DATA_W-1:0] pwdata,
    output logic [nrf_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output nrf_pkg::cfg_t                  cfg
);

    nrf_pkg::cfg_t     cfg_reg;
    nrf_pkg::cfg_reg_t sel;
    logic              wr_en;

    assign sel    = nrf_pkg::cfg_reg_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.near_threshold_mm <= nrf_pkg::THRESH_RST;
            cfg_reg.angle_start       <= nrf_pkg::ANGLE_START_RST;
            cfg_reg.angle_step        <= nrf_pkg::ANGLE_STEP_RST;
            cfg_reg.min_run_points    <= nrf_pkg::MIN_RUN_RST;
        end
        else if (wr_en)
        begin
            case (sel)
                nrf_pkg::REG_NEAR_THRESHOLD:
                    cfg_reg.near_threshold_mm <= pwdata[nrf_pkg::THRESH_W-1:0];
                nrf_pkg::REG_ANGLE_START:
                    cfg_reg.angle_start <= $signed(pwdata[nrf_pkg::ANGLE_START_W-1:0]);
                nrf_pkg::REG_ANGLE_STEP:
                    cfg_reg.angle_step <= pwdata[nrf_pkg::ANGLE_STEP_W-1:0];
                nrf_pkg::REG_MIN_RUN_POINTS:
                    cfg_reg.min_run_points <= pwdata[nrf_pkg::MIN_RUN_W-1:0];
                default:
                    cfg_reg.min_run_points <= cfg_reg.min_run_points;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            nrf_pkg::REG_NEAR_THRESHOLD:
                prdata = nrf_pkg::APB_DATA_W'(cfg_reg.near_threshold_mm);
            nrf_pkg::REG_ANGLE_START:
                prdata = nrf_pkg::APB_DATA_W'(cfg_reg.angle_start);
            nrf_pkg::REG_ANGLE_STEP:
                prdata = nrf_pkg::APB_DATA_W'(cfg_reg.angle_step);
            nrf_pkg::REG_MIN_RUN_POINTS:
                prdata = nrf_pkg::APB_DATA_W'(cfg_reg.min_run_points);
            default:
                prdata = '0;
        endcase
    end

endmodule

// ===== src/nrf_run_tracker.sv =====
// ---------------------------------------------------------------------------
// nrf_run_tracker
// per-sample run bookkeeping; closes the scan and registers the chosen run
// ---------------------------------------------------------------------------
module nrf_run_tracker #(
    parameter int MAX_SCAN  = nrf_pkg::MAX_SCAN_DEF,
    parameter int BEAM_BITS = nrf_pkg::BEAM_BITS_DEF,
    localparam int POS_W    = $clog2(MAX_SCAN),
    localparam int CNT_W    = $clog2(MAX_SCAN + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  logic                 near,
    input  logic [BEAM_BITS-1:0] beam,
    input  logic                 scan_end,
    output logic                 last,
    output logic [CNT_W-1:0]     res_count,
    output logic [POS_W-1:0]     res_first_pos,
    output logic [POS_W-1:0]     res_last_pos,
    output logic [BEAM_BITS-1:0] res_first_beam,
    output logic [BEAM_BITS-1:0] res_last_beam
);

    logic [POS_W-1:0]     pos_reg;
    logic                 far_seen_reg,         far_seen_next;
    logic [CNT_W-1:0]     prefix_len_reg,       prefix_len_next;
    logic [BEAM_BITS-1:0] prefix_last_beam_reg, prefix_last_beam_next;
    logic [CNT_W-1:0]     cur_len_reg,          cur_len_next;
    logic [POS_W-1:0]     cur_first_pos_reg,    cur_first_pos_next;
    logic [BEAM_BITS-1:0] cur_first_beam_reg,   cur_first_beam_next;
    logic [CNT_W-1:0]     best_len_reg,         best_len_next;
    logic [POS_W-1:0]     best_first_pos_reg,   best_first_pos_next;
    logic [POS_W-1:0]     best_last_pos_reg,    best_last_pos_next;
    logic [BEAM_BITS-1:0] best_first_beam_reg,  best_first_beam_next;
    logic [BEAM_BITS-1:0] best_last_beam_reg,   best_last_beam_next;
    logic [BEAM_BITS-1:0] first_beam_reg,       first_beam_next;

    logic [CNT_W-1:0]     res_count_reg,      res_count_next;
    logic [POS_W-1:0]     res_first_pos_reg,  res_first_pos_next;
    logic [POS_W-1:0]     res_last_pos_reg,   res_last_pos_next;
    logic [BEAM_BITS-1:0] res_first_beam_reg, res_first_beam_next;
    logic [BEAM_BITS-1:0] res_last_beam_reg,  res_last_beam_next;

    logic [CNT_W:0]       total;

    assign last = scan_end || (pos_reg == POS_W'(MAX_SCAN - 1));

    always_comb
    begin
        far_seen_next         = far_seen_reg;
        prefix_len_next       = prefix_len_reg;
        prefix_last_beam_next = prefix_last_beam_reg;
        cur_len_next          = cur_len_reg;
        cur_first_pos_next    = cur_first_pos_reg;
        cur_first_beam_next   = cur_first_beam_reg;
        best_len_next         = best_len_reg;
        best_first_pos_next   = best_first_pos_reg;
        best_last_pos_next    = best_last_pos_reg;
        best_first_beam_next  = best_first_beam_reg;
        best_last_beam_next   = best_last_beam_reg;
        first_beam_next       = (pos_reg == '0) ? beam : first_beam_reg;

        if (!far_seen_reg)
        begin
            if (near)
            begin
                prefix_len_next       = prefix_len_reg + 1'b1;
                prefix_last_beam_next = beam;
            end
            else
            begin
                far_seen_next = 1'b1;
            end
        end
        else if (near)
        begin
            if (cur_len_reg == '0)
            begin
                cur_first_pos_next  = pos_reg;
                cur_first_beam_next = beam;
            end
            cur_len_next = cur_len_reg + 1'b1;
            // strictly longer only, so ties keep the earlier run
            if (cur_len_next > best_len_reg)
            begin
                best_len_next        = cur_len_next;
                best_first_pos_next  = cur_first_pos_next;
                best_last_pos_next   = pos_reg;
                best_first_beam_next = cur_first_beam_next;
                best_last_beam_next  = beam;
            end
        end
        else
        begin
            cur_len_next = '0;
        end

        // closing the circle: tail run joined with the run at the scan start
        total = (CNT_W+1)'(cur_len_next) + (CNT_W+1)'(prefix_len_next);

        if (!far_seen_next)
        begin
            // every sample near: the whole scan
            res_count_next      = prefix_len_next;
            res_first_pos_next  = '0;
            res_last_pos_next   = pos_reg;
            res_first_beam_next = first_beam_next;
            res_last_beam_next  = beam;
        end
        else if (total > (CNT_W+1)'(best_len_next))
        begin
            res_count_next      = total[CNT_W-1:0];
            res_first_pos_next  = (cur_len_next != '0) ? cur_first_pos_next : '0;
            res_first_beam_next = (cur_len_next != '0) ? cur_first_beam_next
                                                       : first_beam_next;
            res_last_pos_next   = (prefix_len_next != '0)
                                  ? POS_W'(prefix_len_next - 1'b1) : pos_reg;
            res_last_beam_next  = (prefix_len_next != '0) ? prefix_last_beam_next : beam;
        end
        else
        begin
            res_count_next      = best_len_next;
            res_first_pos_next  = best_first_pos_next;
            res_last_pos_next   = best_last_pos_next;
            res_first_beam_next = best_first_beam_next;
            res_last_beam_next  = best_last_beam_next;
        end

        if (res_count_next == '0)
        begin
            res_first_pos_next = '0;
            res_last_pos_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg              <= '0;
            far_seen_reg         <= 1'b0;
            prefix_len_reg       <= '0;
            prefix_last_beam_reg <= '0;
            cur_len_reg          <= '0;
            cur_first_pos_reg    <= '0;
            cur_first_beam_reg   <= '0;
            best_len_reg         <= '0;
            best_first_pos_reg   <= '0;
            best_last_pos_reg    <= '0;
            best_first_beam_reg  <= '0;
            best_last_beam_reg   <= '0;
            first_beam_reg       <= '0;
        end
        else if (fire)
        begin
            if (last)
            begin
                pos_reg              <= '0;
                far_seen_reg         <= 1'b0;
                prefix_len_reg       <= '0;
                prefix_last_beam_reg <= '0;
                cur_len_reg          <= '0;
                cur_first_pos_reg    <= '0;
                cur_first_beam_reg   <= '0;
                best_len_reg         <= '0;
                best_first_pos_reg   <= '0;
                best_last_pos_reg    <= '0;
                best_first_beam_reg  <= '0;
                best_last_beam_reg   <= '0;
                first_beam_reg       <= '0;
            end
            else
            begin
                pos_reg              <= pos_reg + 1'b1;
                far_seen_reg         <= far_seen_next;
                prefix_len_reg       <= prefix_len_next;
                prefix_last_beam_reg <= prefix_last_beam_next;
                cur_len_reg          <= cur_len_next;
                cur_first_pos_reg    <= cur_first_pos_next;
                cur_first_beam_reg   <= cur_first_beam_next;
                best_len_reg         <= best_len_next;
                best_first_pos_reg   <= best_first_pos_next;
                best_last_pos_reg    <= best_last_pos_next;
                best_first_beam_reg  <= best_first_beam_next;
                best_last_beam_reg   <= best_last_beam_next;
                first_beam_reg       <= first_beam_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && last)
        begin
            res_count_reg      <= res_count_next;
            res_first_pos_reg  <= res_first_pos_next;
            res_last_pos_reg   <= res_last_pos_next;
            res_first_beam_reg <= res_first_beam_next;
            res_last_beam_reg  <= res_last_beam_next;
        end
    end

    assign res_count      = res_count_reg;
    assign res_first_pos  = res_first_pos_reg;
    assign res_last_pos   = res_last_pos_reg;
    assign res_first_beam = res_first_beam_reg;
    assign res_last_beam  = res_last_beam_reg;

    a_scan_restart: assert property (@(posedge clk) disable iff (!rst_n)
        fire && last |=> pos_reg == '0 && best_len_reg == '0)
        else $error("scan state not cleared after closing item");

    a_no_run_before_far: assert property (@(posedge clk) disable iff (!rst_n)
        !far_seen_reg |-> cur_len_reg == '0 && best_len_reg == '0)
        else $error("run counted before the first far sample");

    a_best_bounds_cur: assert property (@(posedge clk) disable iff (!rst_n)
        far_seen_reg |-> best_len_reg >= cur_len_reg)
        else $error("best run shorter than the run in progress");

endmodule

// ===== src/nrf_angle_unit.sv =====
// ---------------------------------------------------------------------------
// nrf_angle_unit
// beam angle: step * beam registered, then start added and saturated to 32 bits
// ---------------------------------------------------------------------------
module nrf_angle_unit #(
    parameter int BEAM_BITS = nrf_pkg::BEAM_BITS_DEF
) (
    input  logic                                     clk,
    input  logic                                     load_prod,
    input  logic                                     load_out,
    input  logic                                     clear,
    input  logic [BEAM_BITS-1:0]                     beam,
    input  logic [nrf_pkg::ANGLE_STEP_W-1:0]         angle_step,
    input  logic signed [nrf_pkg::ANGLE_START_W-1:0] angle_start,
    output logic signed [nrf_pkg::ANGLE_W-1:0]       angle
);

    localparam int PROD_W = nrf_pkg::ANGLE_STEP_W + BEAM_BITS;
    localparam int SUM_W  = nrf_pkg::SUM_W;
    localparam int AW     = nrf_pkg::ANGLE_W;

    localparam logic signed [SUM_W-1:0] SAT_MAX = {{(SUM_W-AW+1){1'b0}}, {(AW-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_MIN = {{(SUM_W-AW+1){1'b1}}, {(AW-1){1'b0}}};

    logic [PROD_W-1:0]        prod_reg;
    logic signed [SUM_W-1:0]  sum;
    logic signed [AW-1:0]     angle_reg, angle_next;

    assign sum = SUM_W'(angle_start) + $signed(SUM_W'(prod_reg));

    always_comb
    begin
        if (clear)
            angle_next = '0;
        else if (sum > SAT_MAX)
            angle_next = SAT_MAX[AW-1:0];
        else if (sum < SAT_MIN)
            angle_next = SAT_MIN[AW-1:0];
        else
            angle_next = sum[AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (load_prod)
            prod_reg <= PROD_W'(angle_step) * PROD_W'(beam);
        if (load_out)
            angle_reg <= angle_next;
    end

    assign angle = angle_reg;

endmodule

// ===== src/near_run_finder.sv =====
// ---------------------------------------------------------------------------
// near_run_finder
// longest circular run of near lidar samples per scan, with its end angles
// ---------------------------------------------------------------------------
//  port group        | dir  | handshake                  | carries
//  sample_*          | in   | sample_valid/sample_stall  | range_mm, beam_index, scan_end
//  result_*          | out  | result_valid/result_stall  | run positions, count, angles, flag
//  apb               | in   | psel/penable/pready        | four config registers
//
//  one sample per cycle unless sample_stall is high; a scan's closing item passes the
//  input reg, then tracker result reg, product reg and output reg to give its result
//  the run tracker updates once per sample; the angle multiply has its own stage
//  no clearing pass: the block takes items right after reset
//  stalls ripple back stage by stage, an empty stage always takes new data
// ---------------------------------------------------------------------------
module near_run_finder #(
    parameter int MAX_SCAN  = nrf_pkg::MAX_SCAN_DEF,
    parameter int BEAM_BITS = nrf_pkg::BEAM_BITS_DEF,
    localparam int POS_W    = $clog2(MAX_SCAN),
    localparam int CNT_W    = $clog2(MAX_SCAN + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              sample_valid,
    output logic                              sample_stall,
    input  logic [nrf_pkg::RANGE_W-1:0]       range_mm,
    input  logic [BEAM_BITS-1:0]              beam_index,
    input  logic                              scan_end,

    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [POS_W-1:0]                  run_first_pos,
    output logic [POS_W-1:0]                  run_last_pos,
    output logic [CNT_W-1:0]                  run_count,
    output logic signed [nrf_pkg::ANGLE_W-1:0] first_angle,
    output logic signed [nrf_pkg::ANGLE_W-1:0] last_angle,
    output logic                              enough_points,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [nrf_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [nrf_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [nrf_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    localparam int CMP_W = (CNT_W > nrf_pkg::MIN_RUN_W) ? CNT_W : nrf_pkg::MIN_RUN_W;

    nrf_pkg::cfg_t cfg;

    logic                 v0_reg, v1_reg, v2_reg, v3_reg;
    logic                 near0_reg;
    logic [BEAM_BITS-1:0] beam0_reg;
    logic                 end0_reg;
    logic                 rdy0, rdy1, rdy2, rdy3;
    logic                 fire0, last0;

    logic [CNT_W-1:0]     t_count;
    logic [POS_W-1:0]     t_first_pos, t_last_pos;
    logic [BEAM_BITS-1:0] t_first_beam, t_last_beam;

    logic [CNT_W-1:0]     count2_reg;
    logic [POS_W-1:0]     first_pos2_reg, last_pos2_reg;

    logic [CNT_W-1:0]     run_count_reg;
    logic [POS_W-1:0]     run_first_pos_reg, run_last_pos_reg;
    logic                 enough_points_reg;

    nrf_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ready chain, output side first
    assign rdy3  = !v3_reg || !result_stall;
    assign rdy2  = !v2_reg || rdy3;
    assign rdy1  = !v1_reg || rdy2;
    // a non-closing item never waits for the result side
    assign fire0 = v0_reg && (!last0 || rdy1);
    assign rdy0  = !v0_reg || fire0;
    assign sample_stall = !rdy0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy0)
                v0_reg <= sample_valid;
            if (rdy1)
                v1_reg <= fire0 && last0;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    // input near compare; user keeps config stable while items are in flight, not enforced
    always_ff @(posedge clk)
    begin
        if (sample_valid && rdy0)
        begin
            near0_reg <= range_mm < cfg.near_threshold_mm;
            beam0_reg <= beam_index;
            end0_reg  <= scan_end;
        end
        if (v1_reg && rdy2)
        begin
            count2_reg     <= t_count;
            first_pos2_reg <= t_first_pos;
            last_pos2_reg  <= t_last_pos;
        end
        if (v2_reg && rdy3)
        begin
            run_count_reg     <= count2_reg;
            run_first_pos_reg <= first_pos2_reg;
            run_last_pos_reg  <= last_pos2_reg;
            enough_points_reg <= CMP_W'(count2_reg) >= CMP_W'(cfg.min_run_points);
        end
    end

    nrf_run_tracker #(
        .MAX_SCAN  (MAX_SCAN),
        .BEAM_BITS (BEAM_BITS)
    ) u_tracker (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (fire0),
        .near           (near0_reg),
        .beam           (beam0_reg),
        .scan_end       (end0_reg),
        .last           (last0),
        .res_count      (t_count),
        .res_first_pos  (t_first_pos),
        .res_last_pos   (t_last_pos),
        .res_first_beam (t_first_beam),
        .res_last_beam  (t_last_beam)
    );

    nrf_angle_unit #(
        .BEAM_BITS (BEAM_BITS)
    ) u_first_angle (
        .clk         (clk),
        .load_prod   (v1_reg && rdy2),
        .load_out    (v2_reg && rdy3),
        .clear       (count2_reg == '0),
        .beam        (t_first_beam),
        .angle_step  (cfg.angle_step),
        .angle_start (cfg.angle_start),
        .angle       (first_angle)
    );

    nrf_angle_unit #(
        .BEAM_BITS (BEAM_BITS)
    ) u_last_angle (
        .clk         (clk),
        .load_prod   (v1_reg && rdy2),
        .load_out    (v2_reg && rdy3),
        .clear       (count2_reg == '0),
        .beam        (t_last_beam),
        .angle_step  (cfg.angle_step),
        .angle_start (cfg.angle_start),
        .angle       (last_angle)
    );

    assign result_valid  = v3_reg;
    assign run_count     = run_count_reg;
    assign run_first_pos = run_first_pos_reg;
    assign run_last_pos  = run_last_pos_reg;
    assign enough_points = enough_points_reg;

    a_empty_run_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && run_count == '0 |->
            first_angle == '0 && last_angle == '0 &&
            run_first_pos == '0 && run_last_pos == '0)
        else $error("empty run reported with nonzero position or angle");

    a_stage1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && !rdy2 |=> v1_reg && $stable(t_count) && $stable(t_first_beam))
        else $error("tracker result lost while downstream stalled");

    a_closing_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        v0_reg && last0 && v1_reg && !rdy2 |=> v0_reg)
        else $error("closing item taken with no room for its result");

endmodule

// ===== tb/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// checks the near run finder against a cycle-free model of its scan tracking
// a directed table opens the run, then randomized scans are sent under several
// register setups; each result is compared field by field with the oldest
// predicted one
// ---------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [10:0]        first_pos;
        logic [10:0]        last_pos;
        logic [11:0]        count;
        logic signed [31:0] first_ang;
        logic signed [31:0] last_ang;
        logic               enough;
    } run_result_t;

    typedef struct packed {
        logic [15:0] rng;
        logic [11:0] beam;
        logic        last;
        logic        typed;
        run_result_t run;
    } stim_row_t;

    localparam run_result_t NO_RUN = '0;

    // opening table, reset register values; expected runs typed in where obvious
    localparam stim_row_t DIR_ROWS [23] = '{
        // one far sample: no run at all
        '{16'd65535, 12'd4095, 1'b1, 1'b1,
          '{11'd0, 11'd0, 12'd0, 32'sd0, 32'sd0, 1'b0}},
        // single near sample
        '{16'd0, 12'd0, 1'b1, 1'b1,
          '{11'd0, 11'd0, 12'd1, -32'sd205887, -32'sd205887, 1'b0}},
        // whole scan near
        '{16'd100, 12'd0, 1'b0, 1'b0, NO_RUN},
        '{16'd1999, 12'd1, 1'b0, 1'b0, NO_RUN},
        '{16'd0, 12'd2, 1'b1, 1'b1,
          '{11'd0, 11'd2, 12'd3, -32'sd205887, -32'sd205063, 1'b0}},
        // wrapping run beats an inner one
        '{16'd5, 12'd10, 1'b0, 1'b0, NO_RUN},
        '{16'd2000, 12'd11, 1'b0, 1'b0, NO_RUN},
        '{16'd7, 12'd12, 1'b0, 1'b0, NO_RUN},
        '{16'd40000, 12'd13, 1'b0, 1'b0, NO_RUN},
        '{16'd1, 12'd14, 1'b1, 1'b0, NO_RUN},
        // tie between an inner run and the closing run: earlier one stays
        '{16'd3000, 12'd100, 1'b0, 1'b0, NO_RUN},
        '{16'd10, 12'd101, 1'b0, 1'b0, NO_RUN},
        '{16'd20, 12'd102, 1'b0, 1'b0, NO_RUN},
        '{16'd65535, 12'd103, 1'b0, 1'b0, NO_RUN},
        '{16'd30, 12'd104, 1'b0, 1'b0, NO_RUN},
        '{16'd40, 12'd105, 1'b1, 1'b0, NO_RUN},
        // only a leading run, scan closes on a far sample
        '{16'd0, 12'd4094, 1'b0, 1'b0, NO_RUN},
        '{16'd1, 12'd4095, 1'b0, 1'b0, NO_RUN},
        '{16'd2000, 12'd0, 1'b1, 1'b0, NO_RUN},
        // top beam index
        '{16'd0, 12'd4095, 1'b1, 1'b1,
          '{11'd0, 11'd0, 12'd1, 32'sd1481253, 32'sd1481253, 1'b0}},
        // lone inner near sample at the threshold edge
        '{16'd2000, 12'd7, 1'b0, 1'b0, NO_RUN},
        '{16'd1999, 12'd8, 1'b0, 1'b0, NO_RUN},
        '{16'd2001, 12'd9, 1'b1, 1'b0, NO_RUN}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        sample_valid;
    logic        sample_stall;
    logic [15:0] range_mm;
    logic [11:0] beam_index;
    logic        scan_end;
    logic        result_valid;
    logic        result_stall;
    logic [10:0] run_first_pos;
    logic [10:0] run_last_pos;
    logic [11:0] run_count;
    logic signed [31:0] first_angle;
    logic signed [31:0] last_angle;
    logic        enough_points;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [nrf_pkg::APB_ADDR_W-1:0] paddr;
    logic [nrf_pkg::APB_DATA_W-1:0] pwdata;
    logic [nrf_pkg::APB_DATA_W-1:0] prdata;
    logic        pready;

    // register copies seen by the predictor
    logic [15:0]        cfg_thresh = nrf_pkg::THRESH_RST;
    logic signed [18:0] cfg_start  = nrf_pkg::ANGLE_START_RST;
    logic [15:0]        cfg_step   = nrf_pkg::ANGLE_STEP_RST;
    logic [11:0]        cfg_min    = nrf_pkg::MIN_RUN_RST;

    // scan tracking state
    logic [10:0] scan_pos        = '0;
    logic        far_hit         = 1'b0;
    logic [11:0] lead_len        = '0;
    logic [11:0] lead_last_beam  = '0;
    logic [11:0] open_len        = '0;
    logic [10:0] open_first_pos  = '0;
    logic [11:0] open_first_beam = '0;
    logic [11:0] top_len         = '0;
    logic [10:0] top_first_pos   = '0;
    logic [10:0] top_last_pos    = '0;
    logic [11:0] top_first_beam  = '0;
    logic [11:0] top_last_beam   = '0;
    logic [11:0] base_beam       = '0;

    run_result_t pending_runs [$];
    int          fail_count  = 0;
    int          cycle_count = 0;
    int          stall_left  = 0;
    bit          quiet_send  = 1'b0;
    bit          quiet_recv  = 1'b0;

    near_run_finder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample_valid  (sample_valid),
        .sample_stall  (sample_stall),
        .range_mm      (range_mm),
        .beam_index    (beam_index),
        .scan_end      (scan_end),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .run_first_pos (run_first_pos),
        .run_last_pos  (run_last_pos),
        .run_count     (run_count),
        .first_angle   (first_angle),
        .last_angle    (last_angle),
        .enough_points (enough_points),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #2 clk = ~clk;

    function automatic logic signed [31:0] beam_to_angle(logic [11:0] beam);
        longint a;
        a = longint'(cfg_start) + longint'(cfg_step) * longint'(beam);
        if (a > longint'(32'sh7fffffff))
            a = longint'(32'sh7fffffff);
        if (a < -longint'(64'h80000000))
            a = -longint'(64'h80000000);
        return a[31:0];
    endfunction

    task automatic track_sample(input logic [15:0] rng, input logic [11:0] beam,
                                input logic end_flag, output bit produced,
                                output run_result_t res);
        logic [10:0] pos;
        logic [10:0] fpos;
        logic [10:0] lpos;
        logic [11:0] cnt;
        logic [11:0] total;
        logic [11:0] fb;
        logic [11:0] lb;
        bit          closing;
        bit          is_near;
        pos      = scan_pos;
        closing  = end_flag || (pos == 11'(nrf_pkg::MAX_SCAN_DEF - 1));
        is_near  = rng < cfg_thresh;
        produced = 1'b0;
        res      = '0;
        if (pos == '0)
            base_beam = beam;
        if (!far_hit)
        begin
            if (is_near)
            begin
                lead_len       = lead_len + 1'b1;
                lead_last_beam = beam;
            end
            else
            begin
                far_hit = 1'b1;
            end
        end
        else if (is_near)
        begin
            if (open_len == '0)
            begin
                open_first_pos  = pos;
                open_first_beam = beam;
            end
            open_len = open_len + 1'b1;
            if (open_len > top_len)
            begin
                top_len        = open_len;
                top_first_pos  = open_first_pos;
                top_last_pos   = pos;
                top_first_beam = open_first_beam;
                top_last_beam  = beam;
            end
        end
        else
        begin
            open_len = '0;
        end

        if (!closing)
        begin
            scan_pos = pos + 1'b1;
        end
        else
        begin
            if (!far_hit)
            begin
                cnt  = lead_len;
                fpos = '0;
                lpos = pos;
                fb   = base_beam;
                lb   = beam;
            end
            else
            begin
                // the wrapping run is weighed last, so a tie keeps the inner one
                total = open_len + lead_len;
                if (total > top_len)
                begin
                    top_len        = total;
                    top_first_pos  = (open_len != '0) ? open_first_pos : 11'd0;
                    top_first_beam = (open_len != '0) ? open_first_beam : base_beam;
                    top_last_pos   = (lead_len != '0) ? 11'(lead_len - 1'b1) : pos;
                    top_last_beam  = (lead_len != '0) ? lead_last_beam : beam;
                end
                cnt  = top_len;
                fpos = top_first_pos;
                lpos = top_last_pos;
                fb   = top_first_beam;
                lb   = top_last_beam;
            end
            produced      = 1'b1;
            res.first_pos = (cnt != '0) ? fpos : 11'd0;
            res.last_pos  = (cnt != '0) ? lpos : 11'd0;
            res.count     = cnt;
            res.first_ang = (cnt != '0) ? beam_to_angle(fb) : 32'sd0;
            res.last_ang  = (cnt != '0) ? beam_to_angle(lb) : 32'sd0;
            res.enough    = cnt >= cfg_min;

            scan_pos        = '0;
            far_hit         = 1'b0;
            lead_len        = '0;
            lead_last_beam  = '0;
            open_len        = '0;
            open_first_pos  = '0;
            open_first_beam = '0;
            top_len         = '0;
            top_first_pos   = '0;
            top_last_pos    = '0;
            top_first_beam  = '0;
            top_last_beam   = '0;
            base_beam       = '0;
        end
    endtask

    task automatic send_sample(input logic [15:0] rng, input logic [11:0] beam,
                               input logic end_flag, input bit typed,
                               input run_result_t typed_run);
        int          gap;
        bit          produced;
        run_result_t predicted;
        if ($urandom_range(0, 24) == 0)
            quiet_send = !quiet_send;
        gap = quiet_send ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        range_mm     <= rng;
        beam_index   <= beam;
        scan_end     <= end_flag;
        @(posedge clk);
        while (sample_stall) @(posedge clk);
        track_sample(rng, beam, end_flag, produced, predicted);
        if (produced)
            pending_runs.insert(pending_runs.size(), typed ? typed_run : predicted);
    endtask

    task automatic write_reg(input nrf_pkg::cfg_reg_t idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        case (idx)
            nrf_pkg::REG_NEAR_THRESHOLD: cfg_thresh = val[15:0];
            nrf_pkg::REG_ANGLE_START:    cfg_start  = val[18:0];
            nrf_pkg::REG_ANGLE_STEP:     cfg_step   = val[15:0];
            nrf_pkg::REG_MIN_RUN_POINTS: cfg_min    = val[11:0];
            default: ;
        endcase
    endtask

    task automatic apply_setup(input int thresh, input int start, input int step,
                               input int min_pts);
        write_reg(nrf_pkg::REG_NEAR_THRESHOLD, 32'(thresh));
        write_reg(nrf_pkg::REG_ANGLE_START, 32'(start));
        write_reg(nrf_pkg::REG_ANGLE_STEP, 32'(step));
        write_reg(nrf_pkg::REG_MIN_RUN_POINTS, 32'(min_pts));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // block is idle once every run is out and the pipeline has drained
    task automatic settle();
        while (pending_runs.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_range(bit want_near);
        if (want_near && cfg_thresh != '0)
            return 16'($urandom_range(0, cfg_thresh - 1));
        return 16'($urandom_range(cfg_thresh, 65535));
    endfunction

    task automatic send_random_scans(input int target);
        int          sent;
        int          len;
        int          style;
        int          pct;
        int          block_left;
        bit          block_near;
        bit          want;
        bit          seq_beams;
        logic [11:0] beam;
        logic [15:0] rng;
        sent = 0;
        while (sent < target)
        begin
            len        = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 300)
                                                     : $urandom_range(1, 40);
            // last scan of the batch is cut to fit the item budget
            if (len > target - sent)
                len = target - sent;
            style      = $urandom_range(0, 4);
            pct        = $urandom_range(0, 100);
            beam       = 12'($urandom_range(0, 4095));
            seq_beams  = $urandom_range(0, 3) != 0;
            block_left = 0;
            block_near = $urandom_range(0, 1);
            for (int i = 0; i < len; i++)
            begin
                case (style)
                    0: want = $urandom_range(1, 100) <= pct;
                    2: want = 1'b1;
                    3: want = 1'b0;
                    default:
                    begin
                        // alternating blocks of near and far samples
                        if (block_left == 0)
                        begin
                            block_near = !block_near;
                            block_left = $urandom_range(1, 12);
                        end
                        block_left--;
                        want = block_near;
                    end
                endcase
                rng = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(0, 65535))
                                                   : pick_range(want);
                send_sample(rng, seq_beams ? beam : 12'($urandom_range(0, 4095)),
                            i == len - 1, 1'b0, NO_RUN);
                beam = beam + 1'b1;
            end
            sent += len;
        end
        sample_valid <= 1'b0;
    endtask

    task automatic report(input string field, input longint want, input longint got);
        $display("%0t: %s expected %0d got %0d", $time, field, want, got);
        fail_count++;
    endtask

    task automatic check_run();
        run_result_t want;
        if (pending_runs.size() == 0)
        begin
            $display("%0t: result with none expected, count %0d", $time, run_count);
            fail_count++;
        end
        else
        begin
            want = pending_runs.pop_front();
            if (run_first_pos !== want.first_pos)
                report("run_first_pos", want.first_pos, run_first_pos);
            if (run_last_pos !== want.last_pos)
                report("run_last_pos", want.last_pos, run_last_pos);
            if (run_count !== want.count)
                report("run_count", want.count, run_count);
            if (first_angle !== want.first_ang)
                report("first_angle", want.first_ang, first_angle);
            if (last_angle !== want.last_ang)
                report("last_angle", want.last_ang, last_angle);
            if (enough_points !== want.enough)
                report("enough_points", want.enough, enough_points);
        end
    endtask

    // result side: stall draw per item, counted down only while a result waits
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stall_left = 0;
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                check_run();
                if ($urandom_range(0, 7) == 0)
                    quiet_recv = !quiet_recv;
                stall_left = quiet_recv ? 0 : $urandom_range(0, 4);
            end
            else if (result_valid && stall_left > 0)
            begin
                stall_left--;
            end
            result_stall <= (stall_left > 0);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[near_run_finder] ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n        <= 1'b0;
        sample_valid <= 1'b0;
        range_mm     <= '0;
        beam_index   <= '0;
        scan_end     <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIR_ROWS[i])
            send_sample(DIR_ROWS[i].rng, DIR_ROWS[i].beam, DIR_ROWS[i].last,
                        DIR_ROWS[i].typed, DIR_ROWS[i].run);
        sample_valid <= 1'b0;
        settle();

        // low extremes: nothing can be near, every scan has enough points
        apply_setup(0, -205887, 0, 0);
        send_random_scans(100);
        settle();

        // high extremes
        apply_setup(65535, 205887, 65535, 2048);
        send_random_scans(100);
        settle();

        for (int p = 0; p < 6; p++)
        begin
            apply_setup($urandom_range(1, 65535),
                        $urandom_range(0, 411774) - 205887,
                        $urandom_range(0, 65535),
                        ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2048)
                                                    : $urandom_range(0, 40));
            send_random_scans(125);
            settle();
        end

        if (fail_count == 0)
            $display("[near_run_finder] OK");
        else
            $display("[near_run_finder] ERROR");
        $finish;
    end

endmodule
